// ----- design/stb_pkg.sv -----
package stb_pkg;

    // opcode values
    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_ALLOCATE = 3'd1;
    localparam logic [2:0] OP_SET      = 3'd2;
    localparam logic [2:0] OP_READ     = 3'd3;
    localparam logic [2:0] OP_LOCK     = 3'd4;
    localparam logic [2:0] OP_DELAY    = 3'd5;

    // count value that marks a locked timer
    localparam logic [15:0] LOCK_VALUE = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  timer_index;
        logic [15:0] duration;
    } stb_in_t;

    typedef struct packed {
        logic [15:0] read_value;
        logic [3:0]  new_index;
        logic        op_ok;
        logic        delay_active;
    } stb_out_t;

endpackage

// ----- design/stb_ram.sv -----
module stb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/software_timer_bank_unit.sv -----
// channel  | direction | payload   | handshake
// s_       | in        | stb_in_t  | s_valid / s_ready
// m_       | out       | stb_out_t | m_valid / m_ready
//
// one item at a time: allocate, set, lock, start delay, a spare opcode and a
//   read of an unallocated timer pass S_EXEC and S_DONE, a read of an allocated
//   timer S_RDWAIT between them; a tick passes S_EXEC, then S_TICK, then S_DONE:
//   the single ram read port walks the allocated timers one per cycle, with the
//   write-back in the cycle after each read, until the last write-back is done
// reset clears the allocation count, the delay counter and all control; the
//   timer ram is not cleared, an entry is written by allocate before any use
// a held result stalls the next item in its last cycle, and the input with it;
//   a new item waits only for the previous one to reach the output register
module software_timer_bank_unit
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  stb_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output stb_out_t m_data
);

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int XW = (CW > 4) ? CW : 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_TICK,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    stb_in_t         item_reg, item_next;
    stb_out_t        res_reg, res_next;
    stb_out_t        m_data_reg, m_data_next;
    logic            m_valid_reg, m_valid_next;
    logic [CW-1:0]   alloc_reg, alloc_next;
    logic [15:0]     delay_reg, delay_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    logic            pend_reg, pend_next;
    logic [AW-1:0]   pend_addr_reg, pend_addr_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [15:0]     ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [15:0]     ram_rdata;
    logic            tick_rd;

    logic [XW-1:0]   idx_x;
    logic [XW-1:0]   alloc_x;
    logic            idx_ok;
    logic [AW-1:0]   idx_addr;

    stb_ram #(
        .WIDTH (16),
        .DEPTH (NUM_TIMERS),
        .ADDR_W(AW)
    ) u_timer_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // index checks against the allocation count
    assign idx_x    = XW'(item_reg.timer_index);
    assign alloc_x  = XW'(alloc_reg);
    assign idx_ok   = idx_x < alloc_x;
    assign idx_addr = idx_x[AW-1:0];

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // next state, ram control and results
    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        alloc_next     = alloc_reg;
        delay_next     = delay_reg;
        ptr_next       = ptr_reg;
        pend_next      = 1'b0;
        pend_addr_next = ptr_reg[AW-1:0];
        ram_we         = 1'b0;
        ram_waddr      = idx_addr;
        ram_wdata      = LOCK_VALUE;
        ram_raddr      = idx_addr;
        tick_rd        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_next              = '0;
                res_next.delay_active = (delay_reg != 16'd0);
                state_next            = S_DONE;
                case (item_reg.opcode)
                    OP_TICK: begin
                        if (delay_reg != 16'd0) begin
                            delay_next = delay_reg - 16'd1;
                        end
                        res_next.op_ok        = 1'b1;
                        res_next.delay_active = (delay_reg > 16'd1);
                        ptr_next              = '0;
                        state_next            = S_TICK;
                    end
                    OP_ALLOCATE: begin
                        if (alloc_x < XW'(NUM_TIMERS)) begin
                            ram_we             = 1'b1;
                            ram_waddr          = alloc_reg[AW-1:0];
                            ram_wdata          = LOCK_VALUE;
                            res_next.new_index = alloc_x[3:0];
                            res_next.op_ok     = 1'b1;
                            alloc_next         = alloc_reg + CW'(1);
                        end
                    end
                    OP_SET: begin
                        if (idx_ok) begin
                            ram_we         = 1'b1;
                            ram_wdata      = item_reg.duration;
                            res_next.op_ok = 1'b1;
                        end
                    end
                    OP_READ: begin
                        res_next.read_value = LOCK_VALUE;
                        if (idx_ok) begin
                            res_next.op_ok = 1'b1;
                            state_next     = S_RDWAIT;
                        end
                    end
                    OP_LOCK: begin
                        if (idx_ok) begin
                            ram_we         = 1'b1;
                            ram_wdata      = LOCK_VALUE;
                            res_next.op_ok = 1'b1;
                        end
                    end
                    OP_DELAY: begin
                        delay_next            = item_reg.duration;
                        res_next.op_ok        = 1'b1;
                        res_next.delay_active = (item_reg.duration != 16'd0);
                    end
                    default: begin
                    end
                endcase
            end
            S_RDWAIT: begin
                res_next.read_value = ram_rdata;
                state_next          = S_DONE;
            end
            S_TICK: begin
                // read one timer per cycle
                if (ptr_reg < alloc_reg) begin
                    tick_rd   = 1'b1;
                    ram_raddr = ptr_reg[AW-1:0];
                    ptr_next  = ptr_reg + CW'(1);
                end
                pend_next = tick_rd;
                // write back the timer read in the previous cycle
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    if (ram_rdata != 16'd0 && ram_rdata != LOCK_VALUE) begin
                        ram_wdata = ram_rdata - 16'd1;
                    end else begin
                        ram_wdata = ram_rdata;
                    end
                end
                if (!tick_rd && !pend_reg) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            alloc_reg   <= '0;
            delay_reg   <= '0;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            alloc_reg   <= alloc_next;
            delay_reg   <= delay_next;
            ptr_reg     <= ptr_next;
            pend_reg    <= pend_next;
        end
        item_reg      <= item_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
        pend_addr_reg <= pend_addr_next;
    end

    // allocation never runs past the bank
    assert property (@(posedge aclk) disable iff (!aresetn)
        alloc_reg <= CW'(NUM_TIMERS))
        else $error("allocation count beyond bank size");

    // tick walk never reads and writes the same timer in one cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        tick_rd && ram_we |-> ram_raddr != ram_waddr)
        else $error("tick read and write-back collide");

    // the timer ram is written only while an item is at work
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_EXEC || state_reg == S_TICK))
        else $error("timer ram written outside of an item");

    // one item at a time: no transfer right after a transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // a finished result reaches the output register when it is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && (!m_valid_reg || m_ready) |=> m_valid && s_ready)
        else $error("result not delivered to output register");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import stb_pkg::*;

    localparam int BANK_SIZE = 16;
    localparam int RANDOM_ITEMS = 925;
    localparam int IDLE_PCT = 19;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 50;

    // opcodes the block decodes as no-ops
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    stb_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    stb_out_t m_data;

    software_timer_bank_unit #(
        .NUM_TIMERS(BANK_SIZE)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ops waiting to be driven, and results owed by the block
    stb_in_t  op_queue[$];
    stb_out_t pending_results[$];

    // shadow copy of the timer bank
    bit [15:0]   count_mem [BANK_SIZE];
    int unsigned alloc_total = 0;
    bit [15:0]   delay_left = '0;

    int items_issued = 0;
    int inputs_taken = 0;
    int results_seen = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;
    int mismatches = 0;
    int op_hist [8];
    int bank_full_hits = 0;
    int index_misses = 0;
    int live_reads = 0;

    // apply one op to the shadow bank and return the answer it owes
    function automatic stb_out_t timer_bank_predict(stb_in_t item);
        stb_out_t res;
        bit       hit;
        res = '0;
        hit = (item.timer_index < alloc_total);
        case (item.opcode)
            OP_TICK: begin
                if (delay_left != 0)
                    delay_left = delay_left - 16'd1;
                for (int i = 0; i < alloc_total; i++) begin
                    if (count_mem[i] != 0 && count_mem[i] != LOCK_VALUE)
                        count_mem[i] = count_mem[i] - 16'd1;
                end
                res.op_ok = 1'b1;
            end
            OP_ALLOCATE: begin
                if (alloc_total < BANK_SIZE) begin
                    res.new_index = alloc_total[3:0];
                    count_mem[alloc_total] = LOCK_VALUE;
                    alloc_total++;
                    res.op_ok = 1'b1;
                end
            end
            OP_SET: begin
                if (hit) begin
                    count_mem[item.timer_index] = item.duration;
                    res.op_ok = 1'b1;
                end
            end
            OP_READ: begin
                res.read_value = LOCK_VALUE;
                if (hit) begin
                    res.read_value = count_mem[item.timer_index];
                    res.op_ok = 1'b1;
                end
            end
            OP_LOCK: begin
                if (hit) begin
                    count_mem[item.timer_index] = LOCK_VALUE;
                    res.op_ok = 1'b1;
                end
            end
            OP_DELAY: begin
                delay_left = item.duration;
                res.op_ok = 1'b1;
            end
            default: begin
            end
        endcase
        res.delay_active = (delay_left != 0);
        return res;
    endfunction

    function automatic void add_op(logic [2:0] op, logic [3:0] idx, logic [15:0] dur);
        stb_in_t item;
        item.opcode = op;
        item.timer_index = idx;
        item.duration = dur;
        op_queue.push_back(item);
    endfunction

    // about half short durations so timers and the delay actually run out
    function automatic logic [15:0] pick_duration();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return 16'($urandom_range(0, 8));
        else if (sel < 52)
            return LOCK_VALUE;
        else if (sel < 58)
            return 16'hFFFE;
        else if (sel < 62)
            return 16'h0000;
        return 16'($urandom);
    endfunction

    // input driver
    always @(posedge aclk) begin : drive_inputs
        bit no_idle;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
        end else if (!s_valid || s_ready) begin
            no_idle = (items_issued >= 450 && items_issued < 620);
            if (op_queue.size() != 0
                    && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_data <= op_queue.pop_front();
                s_valid <= 1'b1;
                items_issued++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // one long output hold-off so the block backs up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (!hold_done && results_seen >= 300) begin
            hold_cnt <= HOLD_OFF_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // result receiver
    always @(posedge aclk) begin : drive_ready
        bit no_idle;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            no_idle = (results_seen >= 450 && results_seen < 620);
            m_ready <= (hold_cnt == 0) && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge aclk) begin : watch_ports
        stb_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result rv=%h ni=%0d ok=%b da=%b",
                                 m_data.read_value, m_data.new_index,
                                 m_data.op_ok, m_data.delay_active);
                end else begin
                    want = pending_results.pop_front();
                    if (want.read_value !== m_data.read_value
                            || want.new_index !== m_data.new_index
                            || want.op_ok !== m_data.op_ok
                            || want.delay_active !== m_data.delay_active) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d: expected rv=%h ni=%0d ok=%b da=%b,",
                                      " got rv=%h ni=%0d ok=%b da=%b"},
                                     results_seen, want.read_value, want.new_index,
                                     want.op_ok, want.delay_active, m_data.read_value,
                                     m_data.new_index, m_data.op_ok, m_data.delay_active);
                    end
                end
                results_seen <= results_seen + 1;
            end
            if (s_valid && s_ready) begin
                want = timer_bank_predict(s_data);
                pending_results.push_back(want);
                inputs_taken <= inputs_taken + 1;
                op_hist[s_data.opcode]++;
                if (s_data.opcode == OP_ALLOCATE && !want.op_ok)
                    bank_full_hits++;
                if ((s_data.opcode == OP_SET || s_data.opcode == OP_READ
                        || s_data.opcode == OP_LOCK) && !want.op_ok)
                    index_misses++;
                if (s_data.opcode == OP_READ && want.op_ok
                        && want.read_value != LOCK_VALUE && want.read_value != 0)
                    live_reads++;
            end
        end
    end

    initial begin : run_test
        int          total_items;
        int          sel;
        int          gen_alloc;
        int          guard;
        logic [3:0]  idx;
        logic [2:0]  op;

        foreach (op_hist[i])
            op_hist[i] = 0;

        // directed: empty bank, delay edges, countdown to zero, locking, spare opcodes
        add_op(OP_READ, 4'd15, 16'h0000);
        add_op(OP_SET, 4'd0, 16'h1234);
        add_op(OP_LOCK, 4'd0, 16'h0000);
        add_op(OP_TICK, 4'd0, 16'h0000);
        add_op(OP_DELAY, 4'd0, 16'h0000);
        add_op(OP_DELAY, 4'd0, 16'h0001);
        add_op(OP_TICK, 4'd15, 16'hFFFF);
        add_op(OP_ALLOCATE, 4'd0, 16'h0000);
        add_op(OP_READ, 4'd0, 16'h0000);
        add_op(OP_SET, 4'd0, 16'h0002);
        add_op(OP_TICK, 4'd0, 16'h0000);
        add_op(OP_READ, 4'd0, 16'h0000);
        add_op(OP_TICK, 4'd0, 16'h0000);
        add_op(OP_TICK, 4'd0, 16'h0000);
        add_op(OP_READ, 4'd0, 16'h0000);
        add_op(OP_SET, 4'd0, LOCK_VALUE);
        add_op(OP_TICK, 4'd0, 16'h0000);
        add_op(OP_READ, 4'd0, 16'h0000);
        add_op(OP_SET, 4'd0, 16'hFFFE);
        add_op(OP_LOCK, 4'd0, 16'h0000);
        add_op(OP_READ, 4'd0, 16'h0000);
        add_op(OP_SPARE_LO, 4'd15, 16'hFFFF);
        add_op(OP_SPARE_HI, 4'd0, 16'h0000);
        add_op(OP_DELAY, 4'd0, 16'hFFFF);
        add_op(OP_READ, 4'd1, 16'h0000);

        // random: mostly ops on allocated timers, allocation slow enough that
        // the bank fills about halfway through
        gen_alloc = 1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            if (gen_alloc > 0 && $urandom_range(0, 99) < 85)
                idx = 4'($urandom_range(0, gen_alloc - 1));
            else
                idx = 4'($urandom);
            if (sel < 30) begin
                add_op(OP_TICK, 4'($urandom), 16'($urandom));
            end else if (sel < 34) begin
                add_op(OP_ALLOCATE, 4'($urandom), 16'($urandom));
                if (gen_alloc < BANK_SIZE)
                    gen_alloc++;
            end else if (sel < 51) begin
                add_op(OP_SET, idx, pick_duration());
            end else if (sel < 71) begin
                add_op(OP_READ, idx, 16'($urandom));
            end else if (sel < 79) begin
                add_op(OP_LOCK, idx, 16'($urandom));
            end else if (sel < 93) begin
                add_op(OP_DELAY, idx, pick_duration());
            end else if (sel < 96) begin
                op = ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
                add_op(op, 4'($urandom), 16'($urandom));
            end else begin
                add_op(3'($urandom), 4'($urandom), 16'($urandom));
                if (op_queue[$].opcode == OP_ALLOCATE && gen_alloc < BANK_SIZE)
                    gen_alloc++;
            end
        end
        total_items = op_queue.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (inputs_taken < total_items)
            @(posedge aclk);
        guard = 0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display({"%0d transfers checked: %0d ticks, %0d allocates (%0d on a full bank),",
                  " %0d sets, %0d reads, %0d locks, %0d delays, %0d spare opcodes"},
                 results_seen, op_hist[OP_TICK], op_hist[OP_ALLOCATE], bank_full_hits,
                 op_hist[OP_SET], op_hist[OP_READ], op_hist[OP_LOCK], op_hist[OP_DELAY],
                 op_hist[OP_SPARE_LO] + op_hist[OP_SPARE_HI]);
        $display({"%0d accesses to unallocated timers, %0d reads of a running timer,",
                  " %0d mismatches, %0d results outstanding"},
                 index_misses, live_reads, mismatches, pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- software_timer_bank_unit.f -----
design/stb_pkg.sv
design/stb_ram.sv
design/software_timer_bank_unit.sv
tb/tb.sv
